@@ design/data_stack_copy_slide_swap_unit_macros.svh @@
// Assertion macros for the data stack unit.
`ifndef DATA_STACK_COPY_SLIDE_SWAP_UNIT_MACROS_SVH
`define DATA_STACK_COPY_SLIDE_SWAP_UNIT_MACROS_SVH

// same-cycle implication
`define DSCSS_CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DSCSS_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/dscss_pkg.sv @@
package dscss_pkg;

   localparam int OFFSET_W = 10;

   typedef enum logic [2:0] {
      OP_PUSH  = 3'd0,
      OP_POP   = 3'd1,
      OP_COPY  = 3'd2,
      OP_SLIDE = 3'd3,
      OP_SWAP  = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_OVER  = 2'd1,
      STAT_UNDER = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DONE = 2'b10
   } state_type;

endpackage

@@ design/dscss_ram.sv @@
module dscss_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word on an address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/data_stack_copy_slide_swap_unit.sv @@
// Data stack with push, pop, copy nth, slide and swap.
// Command channel: req_opcode, req_push_value and req_item_offset are taken
// at a rising edge where start is high and busy is low.
// Result channel: rsp_valid strobes for one cycle with rsp_popped_value,
// rsp_depth_after and rsp_status; the receiver cannot hold a word off.
// Each command: the accept cycle checks depth, issues at most a single RAM
// write and one RAM read, and the next cycle loads the cached top from the
// registered RAM read data, if one was issued, while the result word is shown.
// busy is high during that result cycle, so no new command is taken until it ends.
// The top of stack lives in a register; entries below it live in a
// one-write one-read RAM of STACK_DEPTH words. Slide moves only the depth.
// A failed check (overflow, underflow, bad index, unknown opcode) keeps the
// stack and reports the error status.
// Reset empties the stack at once; the RAM is not cleared and needs no
// clearing pass, since only written entries are ever read.
`include "data_stack_copy_slide_swap_unit_macros.svh"

module data_stack_copy_slide_swap_unit #(
   parameter int STACK_DEPTH = 1024,
   parameter int WORD_WIDTH  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [2:0]             req_opcode,
   input  logic signed [31:0]     req_push_value,
   input  logic [9:0]             req_item_offset,
   output logic                   rsp_valid,
   output logic signed [31:0]     rsp_popped_value,
   output logic [10:0]            rsp_depth_after,
   output dscss_pkg::status_type  rsp_status
);
   import dscss_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int CW = (DW > OFFSET_W) ? DW : OFFSET_W;

   state_type        state_ff, state_in;
   logic [DW-1:0]    depth_ff, depth_in;
   logic [WORD_WIDTH-1:0] top_ff, top_in;
   logic [WORD_WIDTH-1:0] popped_ff, popped_in;
   status_type       status_ff, status_in;
   logic             load_top_ff, load_top_in;

   logic             accept;
   logic [CW-1:0]    d_ext, n_ext, d_m1, d_m2, d_m1_n;
   logic             wr_en, rd_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [WORD_WIDTH-1:0] rd_data, push_word;

   dscss_ram #(
      .DEPTH(STACK_DEPTH),
      .WIDTH(WORD_WIDTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(top_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign busy   = (state_ff == ST_DONE);
   assign accept = start && (state_ff == ST_IDLE);

   assign d_ext     = CW'(depth_ff);
   assign n_ext     = CW'(req_item_offset);
   assign d_m1      = d_ext - CW'(1);
   assign d_m2      = d_ext - CW'(2);
   assign d_m1_n    = d_m1 - n_ext;
   assign push_word = WORD_WIDTH'(req_push_value);

   always_comb begin
      state_in    = state_ff;
      depth_in    = depth_ff;
      top_in      = top_ff;
      popped_in   = popped_ff;
      status_in   = status_ff;
      load_top_in = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = d_m1[AW-1:0];
      rd_en       = 1'b0;
      rd_addr     = d_m2[AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_DONE;
               popped_in = '0;
               status_in = STAT_OK;
               case (opcode_type'(req_opcode))
                  OP_PUSH: begin
                     if (d_ext >= CW'(STACK_DEPTH)) begin
                        status_in = STAT_OVER;
                     end else begin
                        wr_en    = (depth_ff != '0);
                        top_in   = push_word;
                        depth_in = depth_ff + DW'(1);
                     end
                  end
                  OP_POP: begin
                     if (depth_ff == '0) begin
                        status_in = STAT_UNDER;
                     end else begin
                        popped_in   = top_ff;
                        depth_in    = d_m1[DW-1:0];
                        rd_en       = (d_ext >= CW'(2));
                        load_top_in = (d_ext >= CW'(2));
                     end
                  end
                  OP_COPY: begin
                     if (n_ext >= d_ext) begin
                        status_in = STAT_UNDER;
                     end else if (d_ext >= CW'(STACK_DEPTH)) begin
                        status_in = STAT_OVER;
                     end else begin
                        wr_en       = 1'b1;
                        depth_in    = depth_ff + DW'(1);
                        rd_addr     = d_m1_n[AW-1:0];
                        rd_en       = (n_ext != '0);
                        load_top_in = (n_ext != '0);
                     end
                  end
                  OP_SLIDE: begin
                     if (d_ext <= n_ext) begin
                        status_in = STAT_UNDER;
                     end else begin
                        depth_in = DW'(d_ext - n_ext);
                     end
                  end
                  OP_SWAP: begin
                     if (d_ext < CW'(2)) begin
                        status_in = STAT_UNDER;
                     end else begin
                        wr_en       = 1'b1;
                        wr_addr     = d_m2[AW-1:0];
                        rd_en       = 1'b1;
                        load_top_in = 1'b1;
                     end
                  end
                  default: begin
                     status_in = STAT_UNDER;
                  end
               endcase
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
            if (load_top_ff) begin
               top_in = rd_data;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         depth_ff    <= '0;
         load_top_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         depth_ff    <= depth_in;
         load_top_ff <= load_top_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff    <= top_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
   end

   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_popped_value = 32'(popped_ff);
   assign rsp_depth_after  = 11'(depth_ff);
   assign rsp_status       = status_ff;

   `DSCSS_CHECK_NEXT(a_accept_gives_word, accept, rsp_valid, "accepted command gave no result")
   `DSCSS_CHECK_NEXT(a_single_strobe, rsp_valid, !rsp_valid, "result strobe held two cycles")
   `DSCSS_CHECK_NOW(a_depth_bound, 1'b1, d_ext <= CW'(STACK_DEPTH), "depth beyond capacity")
   `DSCSS_CHECK_NOW(a_fail_keeps_depth, rsp_valid && (status_ff != STAT_OK), depth_ff == $past(depth_ff), "failed command changed depth")
   `DSCSS_CHECK_NOW(a_load_only_done, load_top_ff, state_ff == ST_DONE, "top load outside result cycle")

endmodule
